>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define RRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Checked on every clock edge, reset included.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define RRS_ASSERT(lbl, clk, rstn, prop)
`define RRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/rrsrs_pkg.sv
// ----------------------------------------------------------------------------
// rrsrs_pkg
// Shared types and constants of the shortest-remaining quantum scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrsrs_pkg;

  localparam int unsigned RRS_SLOTS = 16;

  localparam logic [7:0] RRS_QUANTUM_RST = 8'd4;

  // input word selector
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ADDED = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RAN   = 2'd2,
    STATUS_IDLE  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input word
    logic scan_clr;    // scan index to slot 0
    logic scan_inc;    // next slot
    logic best_clr;    // forget best candidate
    logic rd_en;       // slot memory read
    logic rd_run;      // read at running (or chosen) slot, else at scan index
    logic add_commit;  // finish add, emit result
    logic start_run;   // chosen slot becomes running job
    logic run_step;    // run one unit, emit result
    logic idle_tick;   // no job, emit idle result
  } rrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_tick;     // offered word is a tick
    logic run_active;
    logic slot_free;   // slot at scan index is free
    logic scan_last;   // scan index at last slot
    logic best_found;
    logic out_free;    // output register can take a result
  } rrs_sts_t;

endpackage

>>> hw/rtl/rrsrs_ctrl.sv
// ----------------------------------------------------------------------------
// rrsrs_ctrl
// Sequencer: add scan, minimum scan, run step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrsrs_ctrl import rrsrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  rrs_sts_t sts_i,
  output rrs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_SEL_SCAN,
    S_SEL_LAST,
    S_SEL_END,
    S_RUN_EXEC
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.best_clr = 1'b1;
          if (!sts_i.in_tick) begin
            state_d = S_ADD_SCAN;
          end else if (sts_i.run_active) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_run = 1'b1;
            state_d      = S_RUN_EXEC;
          end else begin
            state_d = S_SEL_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (sts_i.slot_free || sts_i.scan_last) begin
          if (sts_i.out_free) begin
            cmd_o.add_commit = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_SEL_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_SEL_LAST;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_SEL_LAST: begin
        // last compare in flight
        state_d = S_SEL_END;
      end
      S_SEL_END: begin
        if (sts_i.best_found) begin
          cmd_o.start_run = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_run    = 1'b1;
          state_d         = S_RUN_EXEC;
        end else if (sts_i.out_free) begin
          cmd_o.idle_tick = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RUN_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.run_step = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/rrsrs_dp.sv
// ----------------------------------------------------------------------------
// rrsrs_dp
// Slot table, minimum search, run bookkeeping and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrsrs_dp import rrsrs_pkg::*; #(
  parameter int unsigned SLOTS = RRS_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_cmd_i,
  input  logic [7:0]  in_job_i,
  input  logic [15:0] in_burst_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output status_e     out_status_o,
  output logic [7:0]  out_id_o,
  output logic        out_fin_o,
  output logic [31:0] out_ftime_o,
  output logic [15:0] out_rem_o,
  input  rrs_cmd_t    cmd_i,
  output rrs_sts_t    sts_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  logic [7:0]  job_mem [SLOTS];
  logic [15:0] rem_mem [SLOTS];

  logic [SLOTS-1:0] valid_q;
  logic [7:0]       in_job_q;
  logic [15:0]      in_burst_q;
  logic [IW-1:0]    scan_idx_q;
  logic [IW-1:0]    cmp_idx_q;
  logic             cmp_en_q;
  logic             best_found_q;
  logic [IW-1:0]    best_idx_q;
  logic [15:0]      best_rem_q;
  logic [7:0]       rd_job_q;
  logic [15:0]      rd_rem_q;
  logic             run_active_q;
  logic [IW-1:0]    run_slot_q;
  logic [7:0]       qused_q;
  logic [31:0]      time_q;
  logic [7:0]       quantum_q;
  logic             m_valid_q;
  status_e          status_q;
  logic [7:0]       id_q;
  logic             fin_q;
  logic [31:0]      ftime_q;
  logic [15:0]      orem_q;

  logic          slot_free;
  logic          out_free;
  logic          out_load;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          job_we;
  logic          rem_we;
  logic [15:0]   rem_wdata;
  logic [15:0]   rem_next;
  logic [7:0]    qused_inc;
  logic [31:0]   time_next;
  logic          quantum_hit;
  logic          better;

  assign slot_free = !valid_q[scan_idx_q];
  assign out_free  = !m_valid_q || out_ready_i;
  assign out_load  = cmd_i.add_commit || cmd_i.run_step || cmd_i.idle_tick;

  assign sts_o.in_tick    = (in_cmd_i == CMD_TICK);
  assign sts_o.run_active = run_active_q;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.scan_last  = (scan_idx_q == LastIdx);
  assign sts_o.best_found = best_found_q;
  assign sts_o.out_free   = out_free;

  assign rd_addr = cmd_i.rd_run ? (cmd_i.start_run ? best_idx_q : run_slot_q) : scan_idx_q;
  assign wr_addr = cmd_i.run_step ? run_slot_q : scan_idx_q;

  assign job_we    = cmd_i.add_commit && slot_free;
  assign rem_we    = job_we || cmd_i.run_step;
  assign rem_next  = (rd_rem_q != 16'd0) ? (rd_rem_q - 16'd1) : 16'd0;
  assign rem_wdata = cmd_i.run_step ? rem_next : in_burst_q;

  // saturating quantum counter
  assign qused_inc   = (qused_q != 8'hFF) ? (qused_q + 8'd1) : qused_q;
  assign time_next   = time_q + 32'd1;
  assign quantum_hit = (quantum_q != 8'd0) && (qused_inc == quantum_q);

  // strict less keeps the lowest slot on ties
  assign better = cmp_en_q && valid_q[cmp_idx_q] &&
                  (!best_found_q || (rd_rem_q < best_rem_q));

  // slot memories
  always_ff @(posedge clk_i) begin
    if (job_we) begin
      job_mem[wr_addr] <= in_job_q;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_job_q <= job_mem[rd_addr];
      rd_rem_q <= rem_mem[rd_addr];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_job_q   <= in_job_i;
      in_burst_q <= in_burst_i;
    end
    cmp_idx_q <= scan_idx_q;
    if (better) begin
      best_idx_q <= cmp_idx_q;
      best_rem_q <= rd_rem_q;
    end
    if (out_load) begin
      if (cmd_i.add_commit) begin
        status_q <= slot_free ? STATUS_ADDED : STATUS_FULL;
        id_q     <= 8'd0;
        fin_q    <= 1'b0;
        ftime_q  <= 32'd0;
        orem_q   <= 16'd0;
      end else if (cmd_i.run_step) begin
        status_q <= STATUS_RAN;
        id_q     <= rd_job_q;
        orem_q   <= rem_next;
        fin_q    <= (rem_next == 16'd0);
        ftime_q  <= (rem_next == 16'd0) ? time_next : 32'd0;
      end else begin
        status_q <= STATUS_IDLE;
        id_q     <= 8'd0;
        fin_q    <= 1'b0;
        ftime_q  <= 32'd0;
        orem_q   <= 16'd0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      scan_idx_q   <= '0;
      cmp_en_q     <= 1'b0;
      best_found_q <= 1'b0;
      run_active_q <= 1'b0;
      run_slot_q   <= '0;
      qused_q      <= 8'd0;
      time_q       <= 32'd0;
      quantum_q    <= RRS_QUANTUM_RST;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      if (cmd_i.scan_clr) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_idx_q <= scan_idx_q + IW'(1);
      end
      cmp_en_q <= cmd_i.rd_en && !cmd_i.rd_run;
      if (cmd_i.best_clr) begin
        best_found_q <= 1'b0;
      end else if (better) begin
        best_found_q <= 1'b1;
      end
      if (job_we) begin
        valid_q[scan_idx_q] <= 1'b1;
      end
      if (cmd_i.start_run) begin
        run_active_q <= 1'b1;
        run_slot_q   <= best_idx_q;
        qused_q      <= 8'd0;
      end
      if (cmd_i.idle_tick) begin
        time_q <= time_next;
      end
      if (cmd_i.run_step) begin
        time_q <= time_next;
        if (rem_next == 16'd0) begin
          valid_q[run_slot_q] <= 1'b0;
          run_active_q        <= 1'b0;
          qused_q             <= 8'd0;
        end else if (quantum_hit) begin
          run_active_q <= 1'b0;
          qused_q      <= 8'd0;
        end else begin
          qused_q <= qused_inc;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = m_valid_q;
  assign out_status_o = status_q;
  assign out_id_o     = id_q;
  assign out_fin_o    = fin_q;
  assign out_ftime_o  = ftime_q;
  assign out_rem_o    = orem_q;

  // running job always sits in a live slot
  `RRS_ASSERT(a_run_slot_live, clk_i, rst_ni, run_active_q |-> valid_q[run_slot_q])
  // quantum count only moves while a job holds the processor
  `RRS_ASSERT(a_qused_idle, clk_i, rst_ni, !run_active_q |-> (qused_q == 8'd0))
  // a job is only started from a completed search with a winner
  `RRS_ASSERT(a_start_found, clk_i, rst_ni, cmd_i.start_run |-> (best_found_q && !run_active_q))
  // never overwrite a result that has not been taken
  `RRS_ASSERT(a_no_overwrite, clk_i, rst_ni, out_load |-> (!m_valid_q || out_ready_i))
  `RRS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_valid_q)

endmodule

>>> hw/rtl/round_robin_shortest_remaining_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_shortest_remaining_scheduler_unit
// Quantum scheduler picking the ready job with the least remaining time.
// ----------------------------------------------------------------------------
//
//   channel  dir  fields (lsb first)                                   width
//   s_axis   in   tuser: command | tdata: job_id, burst                1 / 24
//   m_axis   out  tuser: status  | tdata: ran_id, finished,            2 / 64
//                                  finish_time, remaining_left
//   cfg      in   cfg_wr_data_i: quantum, written when cfg_wr_en_i     8
//
// Per word: an add scans from slot 0 to a free slot (or the last slot); a tick
// with a running job reads its slot and runs a step; any other tick scans all
// slots (one slot read per cycle), then last compare, decision, run step or idle.
// Reset (rst_ni low, async) clears valid bits, running job and time; quantum 4.
// A result waits in the output register while the next word is accepted; a
// word stalls only when its result is ready before the previous one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_shortest_remaining_scheduler_unit import rrsrs_pkg::*; #(
  parameter int unsigned SLOTS = RRS_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] job_id, [23:8] burst
  input  logic        s_axis_tuser,  // [0] command: 0 add, 1 tick
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [7:0] ran_id, [8] finished,
                                     // [40:9] finish_time, [56:41] remaining_left
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  // quantum register
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i
);

  rrs_cmd_t    cmd;
  rrs_sts_t    sts;
  status_e     out_status;
  logic [7:0]  out_id;
  logic        out_fin;
  logic [31:0] out_ftime;
  logic [15:0] out_rem;

  // Sequencer: decides add scan / minimum scan / run step per word.
  rrsrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Slot table, search registers, time/quantum state, result register.
  rrsrs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser),
    .in_job_i     (s_axis_tdata[7:0]),
    .in_burst_i   (s_axis_tdata[23:8]),
    .cfg_we_i     (cfg_wr_en_i),
    .cfg_data_i   (cfg_wr_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_id_o     (out_id),
    .out_fin_o    (out_fin),
    .out_ftime_o  (out_ftime),
    .out_rem_o    (out_rem),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // pack result word, pad to 8 bytes
  assign m_axis_tdata = {7'd0, out_rem, out_ftime, out_fin, out_id};
  assign m_axis_tuser = out_status;

endmodule

>>> bench/round_robin_shortest_remaining_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_shortest_remaining_scheduler_unit_test
// Self-checking bench for the quantum scheduler. Streams add and tick words
// into the unit. A scoreboard keeps its own copy of the slot table and predicts
// every result word. Runs six quantum settings under three handshake idling
// mixes.
// ----------------------------------------------------------------------------

module round_robin_shortest_remaining_scheduler_unit_test;
  import rrsrs_pkg::*;

  localparam int unsigned SLOTS           = RRS_SLOTS;
  localparam int unsigned STALL_LIMIT     = 4000;  // quiet cycles before giving up
  localparam int unsigned SETTLE          = 24;    // above the worst tick latency
  localparam int unsigned WORDS_PER_PHASE = 180;   // six phases, ~1250 words in all
  localparam int unsigned PHASES          = 6;
  localparam int unsigned MAX_REPORTS     = 30;

  // one predicted result word, fields as in the m_axis comment of the unit
  typedef struct {
    status_e     status;
    logic [7:0]  ran_id;
    logic        finished;
    logic [31:0] finish_time;
    logic [15:0] remaining_left;
  } sched_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow slot table plus the queue of results still owed
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    logic [7:0]    quantum;
    logic          slot_busy [SLOTS];
    logic [7:0]    slot_id   [SLOTS];
    logic [15:0]   slot_left [SLOTS];
    int            run_slot;        // -1 when no job holds the CPU
    logic [7:0]    run_used;        // units run in the current quantum
    logic [31:0]   now;
    sched_result_t due_results [$];
    int            errors;
    int            seen [4];        // checked results per status
    int            completions;

    function new();
      quantum  = RRS_QUANTUM_RST;
      run_slot = -1;
      run_used = '0;
      now      = '0;
      errors   = 0;
      completions = 0;
      foreach (seen[i]) seen[i] = 0;
      foreach (slot_busy[i]) begin
        slot_busy[i] = 1'b0;
        slot_id[i]   = '0;
        slot_left[i] = '0;
      end
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (slot_busy[i]) if (slot_busy[i]) n++;
      return n;
    endfunction

    // Apply one accepted input word to the shadow table, queue its result.
    function void book_word(logic cmd, logic [23:0] data);
      sched_result_t r;
      r = '{STATUS_ADDED, 8'd0, 1'b0, 32'd0, 16'd0};
      if (cmd != CMD_TICK) begin
        // lowest free slot, else the job is dropped
        r.status = STATUS_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_id[i]   = data[7:0];
            slot_left[i] = data[23:8];
            r.status     = STATUS_ADDED;
            break;
          end
        end
      end else begin
        // pick the least remaining time, lowest slot wins ties
        if (run_slot < 0 || !slot_busy[run_slot]) begin
          run_slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i] && (run_slot < 0 || slot_left[i] < slot_left[run_slot]))
              run_slot = i;
          if (run_slot >= 0) run_used = '0;
        end
        now = now + 32'd1;
        if (run_slot < 0) begin
          r.status = STATUS_IDLE;
        end else begin
          r.status = STATUS_RAN;
          r.ran_id = slot_id[run_slot];
          if (slot_left[run_slot] != 0) slot_left[run_slot] = slot_left[run_slot] - 16'd1;
          if (run_used != 8'hFF) run_used = run_used + 8'd1;
          if (slot_left[run_slot] == 0) begin
            slot_busy[run_slot] = 1'b0;
            run_slot            = -1;
            run_used            = '0;
            r.finished          = 1'b1;
            r.finish_time       = now;
          end else begin
            r.remaining_left = slot_left[run_slot];
            // a zero quantum never expires
            if (quantum != 0 && run_used == quantum) begin
              run_slot = -1;
              run_used = '0;
            end
          end
        end
      end
      due_results.insert(due_results.size(), r);
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [1:0] user, logic [63:0] data);
      sched_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result status %0d data %h", user, data));
        return;
      end
      want = due_results.pop_front();
      if (user != want.status)
        report($sformatf("status %0d, want %0d", user, want.status));
      if (data[7:0] != want.ran_id)
        report($sformatf("ran_id %0d, want %0d", data[7:0], want.ran_id));
      if (data[8] != want.finished)
        report($sformatf("finished %0b, want %0b", data[8], want.finished));
      if (data[40:9] != want.finish_time)
        report($sformatf("finish_time %0d, want %0d", data[40:9], want.finish_time));
      if (data[56:41] != want.remaining_left)
        report($sformatf("remaining_left %0d, want %0d", data[56:41], want.remaining_left));
      seen[want.status]++;
      if (want.finished) completions++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the unit's ports
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;    // [7:0] job_id, [23:8] burst
  logic        s_axis_tuser  = 1'b0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;          // ran_id, finished, finish_time, remaining_left
  logic [1:0]  m_axis_tuser;          // [1:0] status
  logic        cfg_wr_en_i   = 1'b0;
  logic [7:0]  cfg_wr_data_i = '0;

  always #10 clk_i = ~clk_i;

  round_robin_shortest_remaining_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  sched_scoreboard sb;
  int              send_idle_pct = 6;   // chance of a gap cycle before a word
  int              recv_idle_pct = 74;  // chance tready is low on a cycle
  int              words_sent    = 0;
  int unsigned     quiet_cycles  = 0;

  // Result side: random back-pressure, compare every accepted word.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results owed", STALL_LIMIT,
               sb.due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one word, optionally after random gap cycles; returns once accepted.
  // tvalid stays high straight into the next word when no gap is drawn.
  task automatic send_word(input logic cmd, input logic [23:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.book_word(cmd, data);
    words_sent++;
  endtask

  task automatic add_job(input logic [7:0] id, input logic [15:0] burst);
    send_word(~CMD_TICK, {burst, id});
  endtask

  // tdata is don't-care on a tick; random so its bits toggle too
  task automatic tick();
    send_word(CMD_TICK, 24'($urandom));
  endtask

  // Tick share follows table fill so the table neither stays empty nor
  // jams; now and then a flood of adds can force drops.
  task automatic random_word();
    int          busy;
    int          pick;
    int          tick_pct;
    logic [15:0] burst;
    busy     = sb.occupancy();
    tick_pct = (busy >= SLOTS - 3) ? 80 : (busy == 0) ? 35 : 55;
    pick     = $urandom_range(99);
    if (pick < tick_pct) begin
      tick();
    end else if (pick >= 97) begin
      repeat (6) add_job(8'($urandom), 16'($urandom_range(6, 1)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 2)       burst = 16'd0;
      else if (pick < 86) burst = 16'($urandom_range(12, 1));
      else                burst = 16'($urandom_range(200, 13));
      add_job(8'($urandom), burst);
    end
  endtask

  // Stop offering, let every owed result drain plus the worst tick latency.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [7:0] q);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= q;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.quantum = q;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] q;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, quantum at its reset value.
    tick();                      // empty table: idle tick
    add_job(8'h00, 16'h0000);    // id zero with zero burst
    add_job(8'hFF, 16'hFFFF);    // longest burst, parks in its slot
    add_job(8'h55, 16'd3);
    tick();                      // zero burst picked first, done at once
    tick();                      // 3-unit job starts
    add_job(8'h2A, 16'd1);       // add while a job runs, reuses slot 0
    repeat (3) tick();           // running job keeps the CPU, then slot 0 runs
    // fill the table with bursts of 2 and 3 and repeated ids; the last add drops
    for (int k = 0; k < SLOTS; k++)
      add_job(8'hA0 + 8'(k % 8), 16'd2 + 16'(k % 2));

    // Random phases. The zero quantum goes last: a job picked under it may
    // keep the CPU for good, since run_used saturates past any later quantum.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 74;
        recv_idle_pct = 6;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph != 0) begin
        case (ph)
          1:       q = 8'd1;
          2:       q = 8'd255;
          3:       q = 8'($urandom_range(254, 5));
          4:       q = 8'd2;
          default: q = 8'd0;
        endcase
        wait_drained();
        write_quantum(q);
      end
      repeat (WORDS_PER_PHASE) random_word();
    end
    wait_drained();

    $display("covered %0d words: %0d adds, %0d dropped on a full table, %0d idle ticks",
             words_sent, sb.seen[STATUS_ADDED], sb.seen[STATUS_FULL], sb.seen[STATUS_IDLE]);
    $display("%0d run ticks with %0d completions over quanta 4, 1, 255, mid, 2 and 0",
             sb.seen[STATUS_RAN], sb.completions);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
